// ===== hdl/eht_pkg.sv =====
package eht_pkg;

   localparam int TEMP_BITS_DEFAULT = 10;

   localparam logic [7:0] INITIAL_TARGET_RESET    = 8'd40;
   localparam logic [7:0] MAX_SET_TEMP_RESET      = 8'd60;
   localparam logic [8:0] MAX_HEATER_TEMP_RESET   = 9'd100;
   localparam logic [5:0] TOLERANCE_RESET         = 6'd2;
   localparam logic [8:0] UNDER_TEMP_LIMIT_RESET  = 9'h1EC;
   localparam logic [8:0] CASE_OVER_LIMIT_RESET   = 9'd65;
   localparam logic [8:0] HEATER_OVER_LIMIT_RESET = 9'd110;

   localparam logic [7:0] TARGET_STEP = 8'd5;

   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 9;

   localparam logic [2:0] CSR_INITIAL_TARGET    = 3'd0;
   localparam logic [2:0] CSR_MAX_SET_TEMP      = 3'd1;
   localparam logic [2:0] CSR_MAX_HEATER_TEMP   = 3'd2;
   localparam logic [2:0] CSR_TOLERANCE         = 3'd3;
   localparam logic [2:0] CSR_UNDER_TEMP_LIMIT  = 3'd4;
   localparam logic [2:0] CSR_CASE_OVER_LIMIT   = 3'd5;
   localparam logic [2:0] CSR_HEATER_OVER_LIMIT = 3'd6;

   localparam logic [1:0] MODE_STANDBY   = 2'd0;
   localparam logic [1:0] MODE_HEAT      = 2'd1;
   localparam logic [1:0] MODE_COOL      = 2'd2;
   localparam logic [1:0] MODE_VENTILATE = 2'd3;

   localparam logic [1:0] FAULT_NONE   = 2'd0;
   localparam logic [1:0] FAULT_OVER   = 2'd1;
   localparam logic [1:0] FAULT_SENSOR = 2'd2;

   localparam int RSP_DATA_BITS = 16;

endpackage

// ===== hdl/enclosure_heater_thermostat_core.sv =====
// Thermostat core: one control pass per request word, one response word per pass.
// The response word is registered directly from the accepted request.
// Throughput: one word per cycle; the single response register stalls input only
// while its word is held by the consumer.
// Reset (synchronous, active high) returns the control state and the settings to
// their defaults and clears a latched fault; the target starts at the initial target.
module enclosure_heater_thermostat_core #(
   parameter int TEMP_BITS = eht_pkg::TEMP_BITS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // up_level, down_level, select_level, case_temp, heater_temp, zero fill
   input  logic [((3 + 2 * TEMP_BITS + 7) / 8) * 8 - 1:0] req_tdata,
   // sample_valid
   input  logic                               req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // heater_on, fan_on, vent_open, mode[1:0], target_temp[7:0], fault[1:0], zero fill
   output logic [eht_pkg::RSP_DATA_BITS-1:0]  rsp_tdata,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [eht_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [eht_pkg::CSR_DATA_BITS-1:0]  csr_data
);

   // Comparison width: holds any reading, limit and target +/- half band, signed.
   localparam int CW = ((TEMP_BITS > 10) ? TEMP_BITS : 10) + 1;

   // Settings. The initial target is only used at reset, where the setting itself
   // also returns to its default, so that default seeds the target directly.
   logic [7:0] max_set_temp_ff;
   logic [8:0] max_heater_temp_ff;
   logic [5:0] tolerance_ff;
   logic [8:0] under_temp_limit_ff;
   logic [8:0] case_over_limit_ff;
   logic [8:0] heater_over_limit_ff;

   // Control state.
   logic [1:0]                  mode_ff, mode_in;
   logic                        pending_ff, pending_in;
   logic [7:0]                  target_ff, target_in;
   logic signed [TEMP_BITS-1:0] last_case_ff, last_case_in;
   logic signed [TEMP_BITS-1:0] last_heater_ff, last_heater_in;
   logic                        heater_ff, heater_in;
   logic                        fan_ff, fan_in;
   logic                        vent_ff, vent_in;
   logic                        close_vent_ff, close_vent_in;
   logic [2:0]                  prev_buttons_ff;
   logic [1:0]                  pud_ff, pud_in;
   logic [1:0]                  fault_ff, fault_in;

   logic                             rsp_tvalid_ff;
   logic [eht_pkg::RSP_DATA_BITS-1:0] rsp_tdata_ff, rsp_tdata_in;

   logic                        req_accept;
   logic [2:0]                  buttons_now;
   logic signed [TEMP_BITS-1:0] case_temp_word;
   logic signed [TEMP_BITS-1:0] heater_temp_word;

   assign req_tready  = !rsp_tvalid_ff || rsp_tready;
   assign req_accept  = req_tvalid && req_tready;
   assign csr_ready   = 1'b1;
   assign rsp_tvalid  = rsp_tvalid_ff;
   assign rsp_tdata   = rsp_tdata_ff;

   assign buttons_now      = req_tdata[2:0];
   assign case_temp_word   = req_tdata[3 +: TEMP_BITS];
   assign heater_temp_word = req_tdata[3 + TEMP_BITS +: TEMP_BITS];

   always_comb begin
      logic [2:0]           rise;
      logic signed [CW-1:0] case_x;
      logic signed [CW-1:0] heater_x;
      logic signed [CW-1:0] case_over_x;
      logic signed [CW-1:0] heater_over_x;
      logic signed [CW-1:0] under_x;
      logic signed [CW-1:0] heater_low_x;
      logic signed [CW-1:0] max_heater_x;
      logic signed [CW-1:0] lower_x;
      logic signed [CW-1:0] upper_x;
      logic [8:0]           step_up;
      logic [7:0]           stepped;

      rise = buttons_now & ~prev_buttons_ff;

      mode_in        = mode_ff;
      pending_in     = pending_ff;
      target_in      = target_ff;
      last_case_in   = last_case_ff;
      last_heater_in = last_heater_ff;
      heater_in      = heater_ff;
      fan_in         = fan_ff;
      vent_in        = vent_ff;
      close_vent_in  = close_vent_ff;
      pud_in         = pud_ff;
      fault_in       = fault_ff;

      case_over_x   = $signed({{(CW - 9){1'b0}}, case_over_limit_ff});
      heater_over_x = $signed({{(CW - 9){1'b0}}, heater_over_limit_ff});
      under_x       = $signed({{(CW - 9){under_temp_limit_ff[8]}}, under_temp_limit_ff});
      max_heater_x  = $signed({{(CW - 9){1'b0}}, max_heater_temp_ff});
      heater_low_x  = max_heater_x - $signed({{(CW - 6){1'b0}}, tolerance_ff});

      if (fault_ff == eht_pkg::FAULT_NONE) begin
         pud_in = pud_ff | rise[1:0];
         if (req_tuser) begin
            last_case_in   = case_temp_word;
            last_heater_in = heater_temp_word;
         end
      end

      case_x   = $signed({{(CW - TEMP_BITS){last_case_in[TEMP_BITS-1]}}, last_case_in});
      heater_x = $signed({{(CW - TEMP_BITS){last_heater_in[TEMP_BITS-1]}}, last_heater_in});

      if (fault_ff == eht_pkg::FAULT_NONE && req_tuser) begin
         if (case_x >= case_over_x || heater_x >= heater_over_x) begin
            fault_in = eht_pkg::FAULT_OVER;
         end else if (case_x <= under_x || heater_x <= under_x) begin
            fault_in = eht_pkg::FAULT_SENSOR;
         end
         if (fault_in != eht_pkg::FAULT_NONE) begin
            heater_in = 1'b0;
            vent_in   = 1'b1;
         end else begin
            // The fan runs on after heating until the element has cooled.
            if (!heater_ff && heater_x < case_over_x &&
                mode_ff != eht_pkg::MODE_COOL && mode_ff != eht_pkg::MODE_VENTILATE) begin
               fan_in = 1'b0;
            end
            if (heater_x > case_over_x) begin
               fan_in = 1'b1;
            end
         end
      end

      // Target stepping: up first with the upper clamp, then down with the floor.
      step_up = {1'b0, target_ff};
      if (pud_in[0]) begin
         step_up = {1'b0, target_ff} + {1'b0, eht_pkg::TARGET_STEP};
         if (step_up > {1'b0, max_set_temp_ff}) begin
            step_up = {1'b0, max_set_temp_ff};
         end
      end
      stepped = step_up[7:0];
      if (pud_in[1]) begin
         stepped = (step_up[7:0] < eht_pkg::TARGET_STEP) ? 8'd0
                                                         : step_up[7:0] - eht_pkg::TARGET_STEP;
      end

      lower_x = $signed({{(CW - 8){1'b0}}, stepped}) -
                $signed({{(CW - 5){1'b0}}, tolerance_ff[5:1]});
      upper_x = $signed({{(CW - 8){1'b0}}, stepped}) +
                $signed({{(CW - 5){1'b0}}, tolerance_ff[5:1]});

      if (fault_in == eht_pkg::FAULT_NONE) begin
         if (rise[2]) begin
            mode_in    = mode_ff + 2'd1;
            pending_in = 1'b1;
         end

         case (mode_in)
            eht_pkg::MODE_STANDBY: begin
               if (pending_in) begin
                  pending_in = 1'b0;
                  vent_in    = 1'b0;
                  heater_in  = 1'b0;
               end
            end
            eht_pkg::MODE_HEAT: begin
               if (pending_in) begin
                  pending_in = 1'b0;
                  vent_in    = 1'b0;
               end
               target_in = stepped;
               pud_in    = 2'b00;
               // The vent closes once on each switch of the heater.
               if (case_x <= lower_x && heater_x < heater_low_x) begin
                  if (!heater_in) begin
                     close_vent_in = 1'b1;
                  end
                  fan_in    = 1'b1;
                  heater_in = 1'b1;
                  if (close_vent_in) begin
                     vent_in       = 1'b0;
                     close_vent_in = 1'b0;
                  end
               end else if (case_x >= upper_x || heater_x > max_heater_x) begin
                  if (heater_in) begin
                     close_vent_in = 1'b1;
                  end
                  heater_in = 1'b0;
                  if (close_vent_in) begin
                     vent_in       = 1'b0;
                     close_vent_in = 1'b0;
                  end
               end
            end
            eht_pkg::MODE_COOL: begin
               if (pending_in) begin
                  pending_in = 1'b0;
                  vent_in    = 1'b1;
                  fan_in     = 1'b1;
                  heater_in  = 1'b0;
               end
            end
            eht_pkg::MODE_VENTILATE: begin
               if (pending_in) begin
                  pending_in = 1'b0;
                  vent_in    = 1'b0;
                  fan_in     = 1'b1;
                  heater_in  = 1'b0;
               end
            end
            default: begin
               mode_in = mode_ff;
            end
         endcase
      end

      rsp_tdata_in = {1'b0, fault_in, target_in, mode_in, vent_in, fan_in, heater_in};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_set_temp_ff      <= eht_pkg::MAX_SET_TEMP_RESET;
         max_heater_temp_ff   <= eht_pkg::MAX_HEATER_TEMP_RESET;
         tolerance_ff         <= eht_pkg::TOLERANCE_RESET;
         under_temp_limit_ff  <= eht_pkg::UNDER_TEMP_LIMIT_RESET;
         case_over_limit_ff   <= eht_pkg::CASE_OVER_LIMIT_RESET;
         heater_over_limit_ff <= eht_pkg::HEATER_OVER_LIMIT_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            eht_pkg::CSR_MAX_SET_TEMP:      max_set_temp_ff      <= csr_data[7:0];
            eht_pkg::CSR_MAX_HEATER_TEMP:   max_heater_temp_ff   <= csr_data[8:0];
            eht_pkg::CSR_TOLERANCE:         tolerance_ff         <= csr_data[5:0];
            eht_pkg::CSR_UNDER_TEMP_LIMIT:  under_temp_limit_ff  <= csr_data[8:0];
            eht_pkg::CSR_CASE_OVER_LIMIT:   case_over_limit_ff   <= csr_data[8:0];
            eht_pkg::CSR_HEATER_OVER_LIMIT: heater_over_limit_ff <= csr_data[8:0];
            default: begin
               // The initial target and unused indexes leave the settings alone.
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff         <= eht_pkg::MODE_STANDBY;
         pending_ff      <= 1'b1;
         target_ff       <= eht_pkg::INITIAL_TARGET_RESET;
         last_case_ff    <= '0;
         last_heater_ff  <= '0;
         heater_ff       <= 1'b0;
         fan_ff          <= 1'b0;
         vent_ff         <= 1'b1;
         close_vent_ff   <= 1'b1;
         prev_buttons_ff <= 3'b000;
         pud_ff          <= 2'b00;
         fault_ff        <= eht_pkg::FAULT_NONE;
         rsp_tvalid_ff   <= 1'b0;
      end else begin
         if (req_accept) begin
            mode_ff         <= mode_in;
            pending_ff      <= pending_in;
            target_ff       <= target_in;
            last_case_ff    <= last_case_in;
            last_heater_ff  <= last_heater_in;
            heater_ff       <= heater_in;
            fan_ff          <= fan_in;
            vent_ff         <= vent_in;
            close_vent_ff   <= close_vent_in;
            prev_buttons_ff <= buttons_now;
            pud_ff          <= pud_in;
            fault_ff        <= fault_in;
            rsp_tvalid_ff   <= 1'b1;
         end else if (rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_tdata_ff <= rsp_tdata_in;
      end
   end

endmodule
